>>> sv/bpa_pkg.sv
package bpa_pkg;

    localparam int NUM_PAGES = 65536;
    localparam int WORD_BITS = 64;
    localparam int NWORDS    = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W    = $clog2(WORD_BITS);
    localparam int WADDR_W   = $clog2(NWORDS);
    localparam int PAGE_W    = 16;
    localparam int LIM_W     = 17;
    localparam int REQ_W     = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_RESERVE = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ALLOC,
        ST_RANGE,
        ST_OUT
    } state_t;

endpackage

>>> sv/bpa_if.sv
interface bpa_req_if import bpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [PAGE_W-1:0] first_page;
    logic [LIM_W-1:0]  end_page;

    modport source (output valid, output req_type, output first_page, output end_page,
                    input ready);
    modport sink   (input valid, input req_type, input first_page, input end_page,
                    output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_index;
    logic              ok;

    modport source (output valid, output page_index, output ok, input ready);
    modport sink   (input valid, input page_index, input ok, output ready);
endinterface

interface bpa_cfg_if import bpa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LIM_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/bitmap_page_allocator.sv
// First-fit page allocator over a used/free bitmap held in a 1024 x 64 single-port
// memory. After reset the block sets every word to all used and accepts no request
// meanwhile; page_limit writes are taken at any time. A request has an accept step,
// a read and a modify step per bitmap word visited, and a result hand-off that waits
// until the output register is free. A range writes back each word, an allocate only
// the word where it takes a free page. An allocate visits word 0 up to the one
// holding the first free page (or the last word below page_limit), a free or reserve
// range the words from first_page to end_page-1 after clipping. One request is in
// flight at a time; a result can wait in the output register as the next is taken.
module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bpa_cfg_if.sink       cfg,
    bpa_req_if.sink       req,
    bpa_rsp_if.source     rsp
);

    localparam logic [WORD_BITS-1:0] ONES = '1;

    state_t              state_reg, state_next;
    logic [WADDR_W-1:0]  word_reg, word_next;
    logic [WADDR_W-1:0]  last_reg, last_next;
    logic                alloc_reg, alloc_next;
    logic                set_reg, set_next;
    logic [PAGE_W-1:0]   first_reg, first_next;
    logic [PAGE_W-1:0]   cem1_reg, cem1_next;
    logic [PAGE_W-1:0]   res_idx_reg, res_idx_next;
    logic                res_ok_reg, res_ok_next;
    logic [LIM_W-1:0]    page_limit_reg;
    logic                rsp_valid_reg;
    logic [PAGE_W-1:0]   rsp_idx_reg;
    logic                rsp_ok_reg;

    logic [WORD_BITS-1:0] mem [NWORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 we;
    logic [WORD_BITS-1:0] wdata;
    logic                 load;

    logic [LIM_W-1:0]     lim;
    logic [LIM_W-1:0]     lim_m1;
    logic [LIM_W-1:0]     clip_end;
    logic [LIM_W-1:0]     clip_m1;
    logic [WORD_BITS-1:0] alloc_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] low_bit;
    logic [WORD_W-1:0]    bit_idx;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_W-1:0]    hi_shift;

    assign lim      = (page_limit_reg > LIM_W'(NUM_PAGES)) ? LIM_W'(NUM_PAGES)
                                                           : page_limit_reg;
    assign lim_m1   = lim - LIM_W'(1);
    assign clip_end = (req.end_page > lim) ? lim : req.end_page;
    assign clip_m1  = clip_end - LIM_W'(1);

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.page_index = rsp_idx_reg;
    assign rsp.ok         = rsp_ok_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[word_reg] <= wdata;
        end
        rdata_reg <= mem[word_reg];
    end

    always_comb
    begin
        if ({1'b0, word_reg} < lim[LIM_W-1:WORD_W])
        begin
            alloc_mask = ONES;
        end
        else if ({1'b0, word_reg} == lim[LIM_W-1:WORD_W])
        begin
            alloc_mask = ~(ONES << lim[WORD_W-1:0]);
        end
        else
        begin
            alloc_mask = '0;
        end
        if (word_reg == '0)
        begin
            alloc_mask[0] = 1'b0;
        end
        free_bits = ~rdata_reg & alloc_mask;
        low_bit   = free_bits & (~free_bits + WORD_BITS'(1));
    end

    always_comb
    begin
        bit_idx = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (low_bit[b])
            begin
                bit_idx = bit_idx | WORD_W'(b);
            end
        end
    end

    always_comb
    begin
        hi_shift = WORD_W'(WORD_BITS - 1) - cem1_reg[WORD_W-1:0];
        lo_mask  = (word_reg == first_reg[PAGE_W-1:WORD_W]) ? (ONES << first_reg[WORD_W-1:0])
                                                             : ONES;
        hi_mask  = (word_reg == last_reg) ? (ONES >> hi_shift) : ONES;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            word_reg       <= '0;
            page_limit_reg <= LIM_W'(NUM_PAGES);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            if (cfg.valid && cfg.ready)
            begin
                page_limit_reg <= cfg.data;
            end
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg    <= last_next;
        alloc_reg   <= alloc_next;
        set_reg     <= set_next;
        first_reg   <= first_next;
        cem1_reg    <= cem1_next;
        res_idx_reg <= res_idx_next;
        res_ok_reg  <= res_ok_next;
        if (load)
        begin
            rsp_idx_reg <= res_idx_reg;
            rsp_ok_reg  <= res_ok_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        word_next    = word_reg;
        last_next    = last_reg;
        alloc_next   = alloc_reg;
        set_next     = set_reg;
        first_next   = first_reg;
        cem1_next    = cem1_reg;
        res_idx_next = res_idx_reg;
        res_ok_next  = res_ok_reg;
        we           = 1'b0;
        wdata        = rdata_reg;
        load         = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                wdata = ONES;
                if (word_reg == WADDR_W'(NWORDS - 1))
                begin
                    word_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    word_next = word_reg + WADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_idx_next = '0;
                    res_ok_next  = 1'b0;
                    first_next   = req.first_page;
                    set_next     = (req.req_type == REQ_RESERVE);
                    case (req.req_type)
                        REQ_ALLOC:
                        begin
                            alloc_next = 1'b1;
                            word_next  = '0;
                            last_next  = lim_m1[PAGE_W-1:WORD_W];
                            state_next = (lim <= LIM_W'(1)) ? ST_OUT : ST_READ;
                        end
                        REQ_FREE, REQ_RESERVE:
                        begin
                            alloc_next  = 1'b0;
                            res_ok_next = (req.end_page <= lim);
                            word_next   = req.first_page[PAGE_W-1:WORD_W];
                            cem1_next   = clip_m1[PAGE_W-1:0];
                            last_next   = clip_m1[PAGE_W-1:WORD_W];
                            state_next  = ({1'b0, req.first_page} >= clip_end) ? ST_OUT
                                                                                : ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = alloc_reg ? ST_ALLOC : ST_RANGE;
            end
            ST_ALLOC:
            begin
                if (free_bits != '0)
                begin
                    we           = 1'b1;
                    wdata        = rdata_reg | low_bit;
                    res_idx_next = {word_reg, bit_idx};
                    res_ok_next  = 1'b1;
                    state_next   = ST_OUT;
                end
                else if (word_reg == last_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    word_next  = word_reg + WADDR_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_RANGE:
            begin
                we    = 1'b1;
                wdata = set_reg ? (rdata_reg | (lo_mask & hi_mask))
                                : (rdata_reg & ~(lo_mask & hi_mask));
                if (word_reg == last_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    word_next  = word_reg + WADDR_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/bpa_checker.sv
module bpa_checker
    import bpa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [PAGE_W-1:0] rsp_page_index,
    input logic              rsp_ok
);

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_page_index) && $stable(rsp_ok))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_page_index == '0)
        else $error("failed result carries a page index");

    a_index_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_page_index != '0 |-> rsp_ok)
        else $error("page index without ok");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in flight");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_page_index (rsp.page_index),
    .rsp_ok         (rsp.ok)
);
